/* rtl/core/segment_intersection_2d_defines.svh */
// assertion macros for the segment intersection block
// used by the checker module; no other dependencies
`ifndef SEGMENT_INTERSECTION_2D_DEFINES_SVH
`define SEGMENT_INTERSECTION_2D_DEFINES_SVH
// same-cycle implication, disabled while reset is asserted
`define SEGI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("segment intersection check failed");
// next-cycle implication, disabled while reset is asserted
`define SEGI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("segment intersection check failed");
`endif

/* rtl/core/segi_pkg.sv */
// shared types, widths and codes for the segment intersection block
// no dependencies
`default_nettype none
package segi_pkg;
	localparam int COORD_W = 32;
	localparam int CFG_W = 31;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int AREA_W = CROSS_W;
	localparam int DEN_W = AREA_W + 1;
	localparam int QUO_W = COORD_W;
	localparam int REM_W = DEN_W + QUO_W - 1;
	localparam int NUM_W = REM_W + 1;
	localparam int CHUNK_W = 23;
	localparam int NCHUNK = 3;
	localparam int PP_W = CHUNK_W + 1 + COORD_W;
	localparam int AREA_SHIFT = 29;
	localparam int THR_W = CFG_W + AREA_SHIFT;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} pt_t;

	typedef enum logic [1:0] {
		HIT_OVERLAP = 2'd0,
		HIT_END     = 2'd1,
		HIT_CROSS   = 2'd2
	} hit_t;

	typedef enum logic {
		REG_MIN_AREA = 1'b0,
		REG_MIN_DIFF = 1'b1
	} reg_idx_t;

	// result description that rides along with the divider
	typedef struct packed {
		pt_t  res0;
		pt_t  res1;
		logic two;
		hit_t hit;
		logic use_div;
		logic neg_x;
		logic neg_y;
	} div_side_t;

	typedef struct packed {
		logic      valid;
		div_side_t side;
	} div_ctl_t;
endpackage
`default_nettype wire

/* rtl/core/segi_div.sv */
// pipelined restoring divider, one quotient bit per stage, x and y share the divisor
// depends on segi_pkg
`default_nettype none
module segi_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  segi_pkg::div_ctl_t           ctl_in,
	input  logic [segi_pkg::REM_W-1:0]   num_x,
	input  logic [segi_pkg::REM_W-1:0]   num_y,
	input  logic [segi_pkg::DEN_W-1:0]   den,
	output segi_pkg::div_ctl_t           ctl_out,
	output logic [segi_pkg::QUO_W-1:0]   quo_x,
	output logic [segi_pkg::QUO_W-1:0]   quo_y
);
	import segi_pkg::*;

	logic             vld_s  [0:QUO_W];
	div_side_t        side_s [0:QUO_W];
	logic [QUO_W-1:0] qx_s   [0:QUO_W];
	logic [QUO_W-1:0] qy_s   [0:QUO_W];
	logic [REM_W-1:0] rx_s   [0:QUO_W-1];
	logic [REM_W-1:0] ry_s   [0:QUO_W-1];
	logic [DEN_W-1:0] den_s  [0:QUO_W-1];

	assign vld_s[0]  = ctl_in.valid;
	assign side_s[0] = ctl_in.side;
	assign qx_s[0]   = '0;
	assign qy_s[0]   = '0;
	assign rx_s[0]   = num_x;
	assign ry_s[0]   = num_y;
	assign den_s[0]  = den;

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		localparam int SH = QUO_W - 1 - k;
		logic [REM_W-1:0] trial;
		logic             ge_x;
		logic             ge_y;

		assign trial = REM_W'(den_s[k]) << SH;
		assign ge_x  = rx_s[k] >= trial;
		assign ge_y  = ry_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
			qx_s[k+1]   <= {qx_s[k][QUO_W-2:0], ge_x};
			qy_s[k+1]   <= {qy_s[k][QUO_W-2:0], ge_y};
		end

		if (k < QUO_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				rx_s[k+1]  <= ge_x ? rx_s[k] - trial : rx_s[k];
				ry_s[k+1]  <= ge_y ? ry_s[k] - trial : ry_s[k];
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign ctl_out.valid = vld_s[QUO_W];
	assign ctl_out.side  = side_s[QUO_W];
	assign quo_x = qx_s[QUO_W];
	assign quo_y = qy_s[QUO_W];
endmodule
`default_nettype wire

/* rtl/core/segment_intersection_2d.sv */
// the first result is registered out after stages s1 to s9, the divider and the output register;
// a second result (collinear overlap only) follows in the very next cycle
// intake: set by the single result port, a new pair is taken only while busy is low (busy is high
// for the cycle after each transfer); the 32-stage divider and everything else take
// a new pair every cycle. results cannot be held off by the receiver.
// reset clears all valid bits and sets min_area = 1, min_diff = 268
`default_nettype none
module segment_intersection_2d (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [segi_pkg::CFG_W-1:0]    cfg_data,
	// command side
	input  logic                          start,
	output logic                          busy,
	input  logic signed [segi_pkg::COORD_W-1:0] a_start_x,
	input  logic signed [segi_pkg::COORD_W-1:0] a_start_y,
	input  logic signed [segi_pkg::COORD_W-1:0] a_end_x,
	input  logic signed [segi_pkg::COORD_W-1:0] a_end_y,
	input  logic signed [segi_pkg::COORD_W-1:0] b_start_x,
	input  logic signed [segi_pkg::COORD_W-1:0] b_start_y,
	input  logic signed [segi_pkg::COORD_W-1:0] b_end_x,
	input  logic signed [segi_pkg::COORD_W-1:0] b_end_y,
	// result side
	output logic                          result_strobe,
	output logic signed [segi_pkg::COORD_W-1:0] point_x,
	output logic signed [segi_pkg::COORD_W-1:0] point_y,
	output logic [1:0]                    hit_case,
	output logic                          last_point
);
	import segi_pkg::*;

	typedef struct packed {
		logic signed [DIFF_W-1:0] x;
		logic signed [DIFF_W-1:0] y;
	} vec_t;

	function automatic logic signed [DIFF_W-1:0] dsub(coord_t p, coord_t q);
		return DIFF_W'(p) - DIFF_W'(q);
	endfunction

	function automatic vec_t vsub(pt_t p, pt_t q);
		vec_t r;
		r.x = dsub(p.x, q.x);
		r.y = dsub(p.y, q.y);
		return r;
	endfunction

	// coordinate along the chosen axis: x when ax is low, y when high
	function automatic coord_t key(pt_t p, logic ax);
		return ax ? p.y : p.x;
	endfunction

	function automatic logic [DIFF_W-1:0] dabs(logic signed [DIFF_W-1:0] d);
		return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
	endfunction

	// ---------------------------------------------------------------- config
	logic [CFG_W-1:0] min_area_q;
	logic [CFG_W-1:0] min_diff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_area_q <= CFG_W'(1);
			min_diff_q <= CFG_W'(268);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MIN_AREA: min_area_q <= cfg_data;
				REG_MIN_DIFF: min_diff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- intake
	// one transfer, then one blocked cycle, so each pair leaves room for its second output point
	logic accept;
	logic busy_q;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= accept;
		end
	end

	// valid bits for the front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	// box and straddle outcomes, registered in s6
	logic strad_s6, box_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			// drop pairs that fail the box or straddle test
			v_s7 <= v_s6 && box_s6 && strad_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// ---------------------------------------------------------------- s1: input capture
	pt_t a0_s1, a1_s1, b0_s1, b1_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			a0_s1 <= '{x: a_start_x, y: a_start_y};
			a1_s1 <= '{x: a_end_x,   y: a_end_y};
			b0_s1 <= '{x: b_start_x, y: b_start_y};
			b1_s1 <= '{x: b_end_x,   y: b_end_y};
		end
	end

	// ---------------------------------------------------------------- s2: differences, box test
	pt_t  a0_s2, a1_s2, b0_s2, b1_s2;
	vec_t d_b0a0_s2, d_b0a1_s2, d_b0b1_s2, d_a0b0_s2;
	vec_t d_a0a1_s2, d_a0b1_s2, d_a1b0_s2, d_a1b1_s2;
	logic box_s2;
	coord_t amax_x, amax_y, amin_x, amin_y, bmax_x, bmax_y, bmin_x, bmin_y;

	always_comb begin
		amax_x = (a0_s1.x > a1_s1.x) ? a0_s1.x : a1_s1.x;
		amin_x = (a0_s1.x < a1_s1.x) ? a0_s1.x : a1_s1.x;
		amax_y = (a0_s1.y > a1_s1.y) ? a0_s1.y : a1_s1.y;
		amin_y = (a0_s1.y < a1_s1.y) ? a0_s1.y : a1_s1.y;
		bmax_x = (b0_s1.x > b1_s1.x) ? b0_s1.x : b1_s1.x;
		bmin_x = (b0_s1.x < b1_s1.x) ? b0_s1.x : b1_s1.x;
		bmax_y = (b0_s1.y > b1_s1.y) ? b0_s1.y : b1_s1.y;
		bmin_y = (b0_s1.y < b1_s1.y) ? b0_s1.y : b1_s1.y;
	end

	always_ff @(posedge clk) begin
		a0_s2 <= a0_s1;
		a1_s2 <= a1_s1;
		b0_s2 <= b0_s1;
		b1_s2 <= b1_s1;
		d_b0a0_s2 <= vsub(b0_s1, a0_s1);
		d_b0a1_s2 <= vsub(b0_s1, a1_s1);
		d_b0b1_s2 <= vsub(b0_s1, b1_s1);
		d_a0b0_s2 <= vsub(a0_s1, b0_s1);
		d_a0a1_s2 <= vsub(a0_s1, a1_s1);
		d_a0b1_s2 <= vsub(a0_s1, b1_s1);
		d_a1b0_s2 <= vsub(a1_s1, b0_s1);
		d_a1b1_s2 <= vsub(a1_s1, b1_s1);
		box_s2 <= !(amax_x < bmin_x || amax_y < bmin_y ||
			amin_x > bmax_x || amin_y > bmax_y);
	end

	// ---------------------------------------------------------------- s3: cross-product terms
	// cross(u, v) = ux*vy - uy*vx for the four straddle tests and the two areas
	logic signed [PROD_W-1:0] p1a_s3, p1b_s3, p2a_s3, p2b_s3, p3a_s3, p3b_s3;
	logic signed [PROD_W-1:0] p4a_s3, p4b_s3, p5a_s3, p5b_s3, p6a_s3, p6b_s3;
	pt_t  a0_s3, a1_s3, b0_s3, b1_s3;
	logic box_s3;
	logic ax_s3;

	always_ff @(posedge clk) begin
		p1a_s3 <= PROD_W'(d_b0a0_s2.x) * PROD_W'(d_b0b1_s2.y);
		p1b_s3 <= PROD_W'(d_b0a0_s2.y) * PROD_W'(d_b0b1_s2.x);
		p2a_s3 <= PROD_W'(d_b0a1_s2.x) * PROD_W'(d_b0b1_s2.y);
		p2b_s3 <= PROD_W'(d_b0a1_s2.y) * PROD_W'(d_b0b1_s2.x);
		p3a_s3 <= PROD_W'(d_a0b0_s2.x) * PROD_W'(d_a0a1_s2.y);
		p3b_s3 <= PROD_W'(d_a0b0_s2.y) * PROD_W'(d_a0a1_s2.x);
		p4a_s3 <= PROD_W'(d_a0b1_s2.x) * PROD_W'(d_a0a1_s2.y);
		p4b_s3 <= PROD_W'(d_a0b1_s2.y) * PROD_W'(d_a0a1_s2.x);
		p5a_s3 <= PROD_W'(d_a0b0_s2.x) * PROD_W'(d_a1b0_s2.y);
		p5b_s3 <= PROD_W'(d_a0b0_s2.y) * PROD_W'(d_a1b0_s2.x);
		p6a_s3 <= PROD_W'(d_a0b1_s2.x) * PROD_W'(d_a1b1_s2.y);
		p6b_s3 <= PROD_W'(d_a0b1_s2.y) * PROD_W'(d_a1b1_s2.x);
		a0_s3  <= a0_s2;
		a1_s3  <= a1_s2;
		b0_s3  <= b0_s2;
		b1_s3  <= b1_s2;
		box_s3 <= box_s2;
		// dominant axis for the overlap case: x unless segment a is near vertical
		ax_s3  <= !(dabs(d_a0a1_s2.x) > DIFF_W'(min_diff_q));
	end

	// ---------------------------------------------------------------- s4: crosses, axis sort
	logic signed [CROSS_W-1:0] cs1_s4, cs2_s4, cs3_s4, cs4_s4, ca2_s4, ca3_s4;
	pt_t  alo_s4, ahi_s4, blo_s4, bhi_s4, b0_s4, b1_s4;
	logic box_s4;
	logic ax_s4;
	logic swap_a, swap_b;

	assign swap_a = key(a0_s3, ax_s3) > key(a1_s3, ax_s3);
	assign swap_b = key(b0_s3, ax_s3) > key(b1_s3, ax_s3);

	always_ff @(posedge clk) begin
		cs1_s4 <= CROSS_W'(p1a_s3) - CROSS_W'(p1b_s3);
		cs2_s4 <= CROSS_W'(p2a_s3) - CROSS_W'(p2b_s3);
		cs3_s4 <= CROSS_W'(p3a_s3) - CROSS_W'(p3b_s3);
		cs4_s4 <= CROSS_W'(p4a_s3) - CROSS_W'(p4b_s3);
		ca2_s4 <= CROSS_W'(p5a_s3) - CROSS_W'(p5b_s3);
		ca3_s4 <= CROSS_W'(p6a_s3) - CROSS_W'(p6b_s3);
		alo_s4 <= swap_a ? a1_s3 : a0_s3;
		ahi_s4 <= swap_a ? a0_s3 : a1_s3;
		blo_s4 <= swap_b ? b1_s3 : b0_s3;
		bhi_s4 <= swap_b ? b0_s3 : b1_s3;
		b0_s4  <= b0_s3;
		b1_s4  <= b1_s3;
		box_s4 <= box_s3;
		ax_s4  <= ax_s3;
	end

	// ---------------------------------------------------------------- s5: straddle, areas, overlap ends
	logic [AREA_W-1:0] a2_s5, a3_s5;
	logic strad_s5, box_s5, ax_s5;
	pt_t  from_s5, to_s5, b0_s5, b1_s5;
	logic z1, z2, z3, z4;

	assign z1 = cs1_s4 == '0;
	assign z2 = cs2_s4 == '0;
	assign z3 = cs3_s4 == '0;
	assign z4 = cs4_s4 == '0;

	always_ff @(posedge clk) begin
		// sign product <= 0: a zero or opposite signs
		strad_s5 <= (z1 || z2 || (cs1_s4[CROSS_W-1] != cs2_s4[CROSS_W-1])) &&
			(z3 || z4 || (cs3_s4[CROSS_W-1] != cs4_s4[CROSS_W-1]));
		a2_s5 <= ca2_s4[CROSS_W-1] ? AREA_W'(-ca2_s4) : AREA_W'(ca2_s4);
		a3_s5 <= ca3_s4[CROSS_W-1] ? AREA_W'(-ca3_s4) : AREA_W'(ca3_s4);
		from_s5 <= (key(alo_s4, ax_s4) < key(blo_s4, ax_s4)) ? blo_s4 : alo_s4;
		to_s5   <= (key(ahi_s4, ax_s4) > key(bhi_s4, ax_s4)) ? bhi_s4 : ahi_s4;
		b0_s5  <= b0_s4;
		b1_s5  <= b1_s4;
		box_s5 <= box_s4;
		ax_s5  <= ax_s4;
	end

	// ---------------------------------------------------------------- s6: thresholds, weight products
	// a3 and a2 are cut into 23-bit chunks so each multiply stays near 32x32
	logic c2_s6, c3_s6, dz_s6, single_s6;
	logic [DEN_W-1:0] den_s6;
	pt_t  from_s6, to_s6, b0_s6, b1_s6;
	logic signed [PP_W-1:0] ppx3_s6 [0:NCHUNK-1];
	logic signed [PP_W-1:0] ppy3_s6 [0:NCHUNK-1];
	logic signed [PP_W-1:0] ppx2_s6 [0:NCHUNK-1];
	logic signed [PP_W-1:0] ppy2_s6 [0:NCHUNK-1];
	logic [NCHUNK*CHUNK_W-1:0] a2_ext, a3_ext;
	logic [AREA_W-1:0] thr;

	assign a2_ext = (NCHUNK*CHUNK_W)'(a2_s5);
	assign a3_ext = (NCHUNK*CHUNK_W)'(a3_s5);
	assign thr    = AREA_W'({min_area_q, AREA_SHIFT'(0)});

	for (genvar c = 0; c < NCHUNK; c++) begin : g_pp
		logic signed [CHUNK_W:0] ch2, ch3;
		assign ch2 = $signed({1'b0, a2_ext[c*CHUNK_W +: CHUNK_W]});
		assign ch3 = $signed({1'b0, a3_ext[c*CHUNK_W +: CHUNK_W]});
		always_ff @(posedge clk) begin
			ppx3_s6[c] <= PP_W'(ch3) * PP_W'(b0_s5.x);
			ppy3_s6[c] <= PP_W'(ch3) * PP_W'(b0_s5.y);
			ppx2_s6[c] <= PP_W'(ch2) * PP_W'(b1_s5.x);
			ppy2_s6[c] <= PP_W'(ch2) * PP_W'(b1_s5.y);
		end
	end

	always_ff @(posedge clk) begin
		c2_s6  <= a2_s5 < thr;
		c3_s6  <= a3_s5 < thr;
		dz_s6  <= (a2_s5 == '0) && (a3_s5 == '0);
		den_s6 <= DEN_W'(a2_s5) + DEN_W'(a3_s5);
		single_s6 <= dabs(dsub(key(from_s5, ax_s5), key(to_s5, ax_s5))) <
			DIFF_W'(min_diff_q);
		strad_s6 <= strad_s5;
		box_s6  <= box_s5;
		from_s6 <= from_s5;
		to_s6   <= to_s5;
		b0_s6   <= b0_s5;
		b1_s6   <= b1_s5;
	end

	// ---------------------------------------------------------------- s7: case decision, chunk sums
	div_side_t side_d;
	div_side_t side_s7;
	logic signed [NUM_W-1:0] tx3_s7, ty3_s7, tx2_s7, ty2_s7;
	logic [DEN_W-1:0] den_s7;

	function automatic logic signed [NUM_W-1:0] csum(logic signed [PP_W-1:0] p0,
		logic signed [PP_W-1:0] p1, logic signed [PP_W-1:0] p2);
		return NUM_W'(p0) + (NUM_W'(p1) <<< CHUNK_W) + (NUM_W'(p2) <<< (2 * CHUNK_W));
	endfunction

	always_comb begin
		side_d = '0;
		side_d.res0 = b0_s6;
		side_d.res1 = to_s6;
		side_d.hit  = HIT_CROSS;
		if (c2_s6 && c3_s6) begin
			// collinear: overlap ends, or one point when they coincide
			side_d.res0 = from_s6;
			side_d.two  = !single_s6;
			side_d.hit  = HIT_OVERLAP;
		end else if (c2_s6) begin
			side_d.res0 = b0_s6;
			side_d.hit  = HIT_END;
		end else if (c3_s6) begin
			side_d.res0 = b1_s6;
			side_d.hit  = HIT_END;
		end else begin
			// zero total weight falls back to b start
			side_d.use_div = !dz_s6;
		end
	end

	always_ff @(posedge clk) begin
		side_s7 <= side_d;
		tx3_s7  <= csum(ppx3_s6[0], ppx3_s6[1], ppx3_s6[2]);
		ty3_s7  <= csum(ppy3_s6[0], ppy3_s6[1], ppy3_s6[2]);
		tx2_s7  <= csum(ppx2_s6[0], ppx2_s6[1], ppx2_s6[2]);
		ty2_s7  <= csum(ppy2_s6[0], ppy2_s6[1], ppy2_s6[2]);
		den_s7  <= den_s6;
	end

	// ---------------------------------------------------------------- s8: numerators
	logic signed [NUM_W-1:0] nx_s8, ny_s8;
	logic [DEN_W-1:0] den_s8;
	div_side_t side_s8;

	always_ff @(posedge clk) begin
		nx_s8   <= tx3_s7 + tx2_s7;
		ny_s8   <= ty3_s7 + ty2_s7;
		den_s8  <= den_s7;
		side_s8 <= side_s7;
	end

	// ---------------------------------------------------------------- s9: magnitudes for the divider
	logic [REM_W-1:0] mx_s9, my_s9;
	logic [DEN_W-1:0] den_s9;
	div_side_t side_n;
	div_side_t side_s9;
	div_ctl_t  div_in;
	div_ctl_t  div_out;
	logic [QUO_W-1:0] quo_x, quo_y;

	// numerator signs ride along to restore the quotient sign
	always_comb begin
		side_n       = side_s8;
		side_n.neg_x = nx_s8[NUM_W-1];
		side_n.neg_y = ny_s8[NUM_W-1];
	end

	always_ff @(posedge clk) begin
		mx_s9  <= nx_s8[NUM_W-1] ? REM_W'(-nx_s8) : REM_W'(nx_s8);
		my_s9  <= ny_s8[NUM_W-1] ? REM_W'(-ny_s8) : REM_W'(ny_s8);
		den_s9 <= den_s8;
		side_s9 <= side_n;
	end

	assign div_in.valid = v_s9;
	assign div_in.side  = side_s9;

	// quotient magnitude fits 32 bits: the point is a convex mix of b's ends
	segi_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (div_in),
		.num_x   (mx_s9),
		.num_y   (my_s9),
		.den     (den_s9),
		.ctl_out (div_out),
		.quo_x   (quo_x),
		.quo_y   (quo_y)
	);

	// ---------------------------------------------------------------- output
	// first point goes out at once, a second one in the cycle after
	pt_t  first_pt;
	pt_t  second_q;
	logic pend_q;
	logic strobe_q;
	pt_t  pt_q;
	hit_t hit_q;
	logic last_q;

	always_comb begin
		first_pt = div_out.side.res0;
		if (div_out.side.use_div) begin
			first_pt.x = div_out.side.neg_x ? coord_t'(-quo_x) : coord_t'(quo_x);
			first_pt.y = div_out.side.neg_y ? coord_t'(-quo_y) : coord_t'(quo_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			strobe_q <= div_out.valid || pend_q;
			pend_q   <= div_out.valid && div_out.side.two;
		end
	end

	always_ff @(posedge clk) begin
		if (div_out.valid) begin
			pt_q     <= first_pt;
			hit_q    <= div_out.side.hit;
			last_q   <= !div_out.side.two;
			second_q <= div_out.side.res1;
		end else if (pend_q) begin
			pt_q   <= second_q;
			last_q <= 1'b1;
		end
	end

	assign result_strobe = strobe_q;
	assign point_x       = pt_q.x;
	assign point_y       = pt_q.y;
	assign hit_case      = hit_q;
	assign last_point    = last_q;
endmodule
`default_nettype wire

/* rtl/core/segi_checker.sv */
// port-level checks for the segment intersection block, bound to the top level
// depends on segi_pkg and segment_intersection_2d_defines.svh
`default_nettype none
`include "segment_intersection_2d_defines.svh"
module segi_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_strobe,
	input logic [1:0] hit_case,
	input logic       last_point
);
	import segi_pkg::*;

	// a transfer blocks the next cycle, and only that one
	`SEGI_ASSERT_NXT(a_busy_after_xfer, clk, arst_n, start && !busy, busy)
	`SEGI_ASSERT_NXT(a_busy_one_cycle, clk, arst_n, busy, !busy)
	// only a collinear overlap yields two points, back to back
	`SEGI_ASSERT_IMP(a_two_is_overlap, clk, arst_n, result_strobe && !last_point,
		hit_case == HIT_OVERLAP)
	`SEGI_ASSERT_NXT(a_second_follows, clk, arst_n, result_strobe && !last_point,
		result_strobe && last_point)
endmodule

bind segment_intersection_2d segi_checker u_segi_checker (.*);
`default_nettype wire

/* sim/segment_intersection_2d_tb.sv */
// testbench for segment_intersection_2d: drives segment pairs, predicts the
// intersection points and checks every result transfer; depends on segi_pkg
`timescale 1ns / 100ps
`default_nettype none
module segment_intersection_2d_tb;
	import segi_pkg::*;

	typedef logic signed [127:0] wide_t;
	// order: a start x/y, a end x/y, b start x/y, b end x/y
	typedef coord_t seg_pair_t [8];

	typedef struct {
		coord_t x;
		coord_t y;
		hit_t   hit;
		logic   last;
	} point_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	coord_t a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
	coord_t b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
	logic result_strobe;
	coord_t point_x, point_y;
	logic [1:0] hit_case;
	logic last_point;

	// local copy of the two thresholds
	logic [CFG_W-1:0] area_thr = 31'd1;
	logic [CFG_W-1:0] diff_tol = 31'd268;

	point_res_t expected_points[$];
	int error_count = 0;
	int gap_pct = 0;

	segment_intersection_2d dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.a_start_x(a_start_x), .a_start_y(a_start_y), .a_end_x(a_end_x), .a_end_y(a_end_y),
		.b_start_x(b_start_x), .b_start_y(b_start_y), .b_end_x(b_end_x), .b_end_y(b_end_y),
		.result_strobe(result_strobe), .point_x(point_x), .point_y(point_y),
		.hit_case(hit_case), .last_point(last_point)
	);

	always #4 clk = ~clk;

	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic wide_t cross2(wide_t ux, wide_t uy, wide_t vx, wide_t vy);
		return ux * vy - uy * vx;
	endfunction

	function automatic int sgn(wide_t v);
		return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
	endfunction

	function automatic wide_t wabs(wide_t v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint lmax(longint a, longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic longint lmin(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	// pushes the points that one segment pair produces
	task automatic predict_intersection(input seg_pair_t s);
		longint p[4][2];
		longint t0, t1;
		wide_t a2, a3, thr, den, qx, qy;
		int s1, s2, s3, s4, ax, fi, ti;
		logic c2, c3;
		point_res_t r;
		for (int i = 0; i < 4; i++) begin
			p[i][0] = s[2*i];
			p[i][1] = s[2*i+1];
		end
		// bounding boxes disjoint: nothing comes out
		if (lmax(p[0][0], p[1][0]) < lmin(p[2][0], p[3][0]) ||
				lmax(p[0][1], p[1][1]) < lmin(p[2][1], p[3][1]) ||
				lmin(p[0][0], p[1][0]) > lmax(p[2][0], p[3][0]) ||
				lmin(p[0][1], p[1][1]) > lmax(p[2][1], p[3][1]))
			return;
		// straddle test from cross product signs
		s1 = sgn(cross2(p[2][0] - p[0][0], p[2][1] - p[0][1], p[2][0] - p[3][0], p[2][1] - p[3][1]));
		s2 = sgn(cross2(p[2][0] - p[1][0], p[2][1] - p[1][1], p[2][0] - p[3][0], p[2][1] - p[3][1]));
		s3 = sgn(cross2(p[0][0] - p[2][0], p[0][1] - p[2][1], p[0][0] - p[1][0], p[0][1] - p[1][1]));
		s4 = sgn(cross2(p[0][0] - p[3][0], p[0][1] - p[3][1], p[0][0] - p[1][0], p[0][1] - p[1][1]));
		if (!(s1 * s2 <= 0 && s3 * s4 <= 0))
			return;
		a2 = wabs(cross2(p[0][0] - p[2][0], p[0][1] - p[2][1], p[1][0] - p[2][0], p[1][1] - p[2][1]));
		a3 = wabs(cross2(p[0][0] - p[3][0], p[0][1] - p[3][1], p[1][0] - p[3][0], p[1][1] - p[3][1]));
		thr = wide_t'(area_thr) << AREA_SHIFT;
		c2 = a2 < thr;
		c3 = a3 < thr;
		if (c2 && c3) begin
			// collinear: clip along the dominant axis
			ax = ((p[0][0] - p[1][0] < 0 ? p[1][0] - p[0][0] : p[0][0] - p[1][0]) >
				longint'(diff_tol)) ? 0 : 1;
			if (p[0][ax] > p[1][ax]) begin
				t0 = p[0][0]; t1 = p[0][1];
				p[0][0] = p[1][0]; p[0][1] = p[1][1];
				p[1][0] = t0; p[1][1] = t1;
			end
			if (p[2][ax] > p[3][ax]) begin
				t0 = p[2][0]; t1 = p[2][1];
				p[2][0] = p[3][0]; p[2][1] = p[3][1];
				p[3][0] = t0; p[3][1] = t1;
			end
			fi = (p[0][ax] < p[2][ax]) ? 2 : 0;
			ti = (p[1][ax] > p[3][ax]) ? 3 : 1;
			t0 = p[fi][ax] - p[ti][ax];
			if (t0 < 0)
				t0 = -t0;
			r.x = coord_t'(p[fi][0]);
			r.y = coord_t'(p[fi][1]);
			r.hit = HIT_OVERLAP;
			if (t0 < longint'(diff_tol)) begin
				r.last = 1'b1;
				expected_points.push_back(r);
			end else begin
				r.last = 1'b0;
				expected_points.push_back(r);
				r.x = coord_t'(p[ti][0]);
				r.y = coord_t'(p[ti][1]);
				r.last = 1'b1;
				expected_points.push_back(r);
			end
			return;
		end
		r.last = 1'b1;
		if (c2 || c3) begin
			// the end of b that lies on a; both on a was handled as an overlap above
			r.hit = HIT_END;
			r.x = coord_t'(c2 ? p[2][0] : p[3][0]);
			r.y = coord_t'(c2 ? p[2][1] : p[3][1]);
			expected_points.push_back(r);
			return;
		end
		r.hit = HIT_CROSS;
		den = a2 + a3;
		if (den == 0) begin
			r.x = coord_t'(p[2][0]);
			r.y = coord_t'(p[2][1]);
		end else begin
			// signed division truncates toward zero
			qx = (a3 * wide_t'(p[2][0]) + a2 * wide_t'(p[3][0])) / den;
			qy = (a3 * wide_t'(p[2][1]) + a2 * wide_t'(p[3][1])) / den;
			r.x = qx[COORD_W-1:0];
			r.y = qy[COORD_W-1:0];
		end
		expected_points.push_back(r);
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// every strobed result is a transfer; compare against the oldest expectation
	always @(posedge clk) begin
		point_res_t e;
		if (arst_n && result_strobe) begin
			if (expected_points.size() == 0) begin
				report_mismatch("unexpected result", point_x, 0);
			end else begin
				e = expected_points.pop_front();
				if (point_x !== e.x)
					report_mismatch("point_x", point_x, e.x);
				if (point_y !== e.y)
					report_mismatch("point_y", point_y, e.y);
				if (hit_case !== e.hit)
					report_mismatch("hit_case", hit_case, e.hit);
				if (last_point !== e.last)
					report_mismatch("last_point", last_point, e.last);
			end
		end
	end

	// ---------------------------------------------------------------- driving

	// presents one pair until the transfer happens, then maybe idles
	task automatic send_pair(input seg_pair_t s);
		a_start_x <= s[0]; a_start_y <= s[1]; a_end_x <= s[2]; a_end_y <= s[3];
		b_start_x <= s[4]; b_start_y <= s[5]; b_end_x <= s[6]; b_end_y <= s[7];
		start <= 1'b1;
		// busy is sampled before the edge updates it
		do @(posedge clk); while (busy);
		predict_intersection(s);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// lets the pipeline empty; pairs with no result may still be in flight
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// write enable stays high; the caller drops it after the last write
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_MIN_AREA)
			area_thr = val;
		else
			diff_tol = val;
	endtask

	task automatic set_thresholds(input logic [CFG_W-1:0] area, input logic [CFG_W-1:0] diff);
		drain();
		write_reg(REG_MIN_AREA, area);
		write_reg(REG_MIN_DIFF, diff);
		cfg_we <= 1'b0;
	endtask

	function automatic seg_pair_t mk(longint ax0, longint ay0, longint ax1, longint ay1,
			longint bx0, longint by0, longint bx1, longint by1);
		seg_pair_t s;
		s = '{coord_t'(ax0), coord_t'(ay0), coord_t'(ax1), coord_t'(ay1),
			coord_t'(bx0), coord_t'(by0), coord_t'(bx1), coord_t'(by1)};
		return s;
	endfunction

	function automatic longint srand(int range);
		return longint'($urandom_range(2 * range)) - range;
	endfunction

	// random pair, weighted toward shapes that get past the rejection tests
	function automatic seg_pair_t random_pair();
		seg_pair_t s;
		longint px, py, dx, dy, k[4];
		int sh, kind;
		kind = $urandom_range(99);
		if (kind < 15) begin
			// raw noise over the whole range, toggles every bit
			foreach (s[i]) s[i] = coord_t'($urandom);
			return s;
		end
		if (kind < 45) begin
			// loose pairs in a random sized box, often crossing
			sh = $urandom_range(31);
			foreach (s[i]) s[i] = coord_t'($urandom) >>> sh;
			return s;
		end
		// points along one line through a base point
		px = srand(1 << 30);
		py = srand(1 << 30);
		dx = ($urandom_range(9) == 0) ? 0 : srand(4096);
		dy = ($urandom_range(9) == 0) ? 0 : srand(4096);
		foreach (k[i]) k[i] = srand(200);
		s = mk(px + k[0] * dx, py + k[0] * dy, px + k[1] * dx, py + k[1] * dy,
			px + k[2] * dx, py + k[2] * dy, px + k[3] * dx, py + k[3] * dy);
		if (kind < 70) begin
			// one end of b off the line, or both when the two shifted words span the ends
			sh = $urandom_range(4, 6);
			s[sh] = s[sh] + coord_t'(srand(1 << 20));
			s[sh + 1] = s[sh + 1] + coord_t'(srand(1 << 20));
			if ($urandom_range(1)) begin
				// swap b ends so either end is the one on a
				{s[4], s[5], s[6], s[7]} = {s[6], s[7], s[4], s[5]};
			end
		end else if (kind < 80) begin
			// near the area threshold
			s[5] = s[5] + coord_t'(srand(3));
		end
		return s;
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		longint mx, mnv;
		mx = 64'sd2147483647;
		mnv = -64'sd2147483648;
		send_pair(mk(mnv, mnv, mx, mx, mnv, mx, mx, mnv));         // full range x crossing
		send_pair(mk(mx, mx, mnv, mnv, mx, mnv, mnv, mx));
		send_pair(mk(mnv, mnv, mnv, mnv, mnv, mnv, mnv, mnv));     // all degenerate at min
		send_pair(mk(mx, mx, mx, mx, mx, mx, mx, mx));             // all degenerate at max
		send_pair(mk(0, 0, 1000, 1000, 0, 1000, 1000, 0));         // proper crossing
		send_pair(mk(0, 0, 1000, 0, 0, 10, 1000, 10));             // parallel, boxes apart
		send_pair(mk(0, 0, 1000, 1000, 600, 0, 1000, 300));        // boxes meet, no straddle
		send_pair(mk(0, 0, 100000, 0, 20000, 0, 300000, 0));       // collinear overlap along x
		send_pair(mk(0, 0, 0, 100000, 0, 50000, 0, 400000));       // collinear along y
		send_pair(mk(0, 0, 100, 0, 100, 0, 5000, 0));              // overlap collapses to one point
		send_pair(mk(0, 0, 0, 5000, 0, 5000, 0, 9000));            // y axis, ends coincide
		send_pair(mk(0, 0, 100000, 0, 50000, 0, 50000, 80000));    // b start on a
		send_pair(mk(0, 0, 100000, 0, 50000, 80000, 50000, 0));    // b end on a
		send_pair(mk(-5000, -300, 7000, 900, 1000, -4000, -200, 6000));
		send_pair(mk(mx, 0, mnv, 0, 0, mx, 0, mnv));               // axes crossing at origin
		drain();
		// zero threshold: exact collinear pairs fall to the crossing path with zero weight
		set_thresholds('0, 31'd268);
		send_pair(mk(0, 0, 100000, 0, 20000, 0, 300000, 0));
		send_pair(mk(0, 0, 0, 100000, 0, 50000, 0, 400000));
		send_pair(mk(0, 0, 1000, 1000, 0, 1000, 1000, 0));
		set_thresholds(31'd1, 31'd268);
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_pair(random_pair());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 9;
		test_directed();
		test_random(250);
		set_thresholds('1, '1);
		test_random(150);
		set_thresholds('0, '0);
		test_random(150);

		gap_pct = 59;
		set_thresholds(31'($urandom), 31'($urandom_range(4096)));
		test_random(200);
		set_thresholds(31'($urandom_range(1 << 16)), 31'($urandom));
		test_random(150);

		gap_pct = 0;
		set_thresholds(31'd1, 31'd268);
		test_random(300);
		drain();

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

/* segment_intersection_2d.f */
+incdir+rtl/core
rtl/core/segi_pkg.sv
rtl/core/segi_div.sv
rtl/core/segment_intersection_2d.sv
rtl/core/segi_checker.sv
sim/segment_intersection_2d_tb.sv
